>>> design/qmhq_pkg.sv
// shared constants and types for the quaternary min-heap queue
package qmhq_pkg;
    localparam int Capacity   = 1024;
    localparam int KeyWidth   = 32;
    localparam int IndexWidth = 20;
    localparam int EntryWidth = KeyWidth + IndexWidth;
    localparam int AddrWidth  = $clog2(Capacity + 1);
    localparam int CountWidth = $clog2(Capacity + 1);

    typedef logic [KeyWidth-1:0]   t_key;
    typedef logic [IndexWidth-1:0] t_index;
    typedef logic [AddrWidth-1:0]  t_addr;
    typedef logic [CountWidth-1:0] t_count;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic   operation;
        t_key   key_in;
        t_index item_index;
    } t_req;

    typedef struct packed {
        t_index popped_index;
        t_key   popped_key;
        t_count entry_count;
        t_err   error;
    } t_rsp;
endpackage

>>> design/qmhq_stream_if.sv
// valid/ready channel carrying one payload
interface qmhq_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/quaternary_min_heap_queue_unit.sv
// top level of the 4-ary min-heap priority queue
// push reads and compares one parent per level and writes the moved entry as it climbs;
// pop reads the root, the last entry, then each child per level, with a decide step per level
// push while full and pop while empty go straight to the response state; one ram port bounds it all
// one operation at a time; the next request can transfer in the cycle after the response transfer
// synchronous active-low reset clears the count and control; store contents are not
// cleared, only slots 1..count are read
module quaternary_min_heap_queue_unit
    import qmhq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    qmhq_stream_if.sink     i_req,
    qmhq_stream_if.source   o_rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_PUSH_RD, S_PUSH_WT, S_PUSH_CMP,
        S_POP_RD_ROOT, S_POP_WT_ROOT, S_POP_RD_LAST, S_POP_WT_LAST,
        S_DN_RD, S_DN_WT, S_DN_CMP, S_DN_DEC, S_DONE
    } t_state;

    t_state r_state;
    t_count r_count;
    t_addr  r_cur, r_up, r_child, r_best, r_first;
    t_key   r_key, r_best_key;
    t_index r_idx, r_best_idx;
    t_rsp   r_rsp;
    logic   r_out_valid;

    logic                  ram_we;
    t_addr                 ram_addr;
    logic [EntryWidth-1:0] ram_wdata, ram_rdata;
    t_key                  rd_key;
    t_index                rd_idx;

    assign rd_key = ram_rdata[EntryWidth-1:IndexWidth];
    assign rd_idx = ram_rdata[IndexWidth-1:0];

    qmhq_ram #(.Width(EntryWidth), .Depth(2 ** AddrWidth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // ram port: address and write selection per state
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_cur;
        ram_wdata = {r_key, r_idx};
        unique case (r_state)
            S_PUSH_RD:     ram_addr = r_up;
            S_PUSH_WT:     ram_addr = r_up;
            S_PUSH_CMP: begin
                ram_we = 1'b1;
                if (r_up != '0 && rd_key > r_key) begin
                    ram_wdata = ram_rdata;
                end
            end
            S_POP_RD_ROOT: ram_addr = t_addr'(1);
            S_POP_RD_LAST: ram_addr = t_addr'(r_count);
            S_DN_RD:       ram_addr = r_child;
            S_DN_WT:       ram_addr = r_child;
            S_DN_DEC: begin
                ram_we = 1'b1;
                if (r_first <= t_addr'(r_count) && !(r_key < r_best_key)) begin
                    ram_wdata = {r_best_key, r_best_idx};
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_key          <= i_req.data.key_in;
                        r_idx          <= i_req.data.item_index;
                        r_rsp.popped_index <= '0;
                        r_rsp.popped_key   <= '0;
                        r_rsp.entry_count  <= r_count;
                        if (i_req.data.operation == OP_PUSH) begin
                            if (r_count >= t_count'(Capacity)) begin
                                r_rsp.error <= ERR_FULL;
                                r_state     <= S_DONE;
                            end else begin
                                r_rsp.error <= ERR_OK;
                                r_count <= r_count + 1'b1;
                                r_cur   <= t_addr'(r_count + 1'b1);
                                r_up    <= t_addr'((r_count + 3'd3) >> 2);
                                r_state <= S_PUSH_RD;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_rsp.error <= ERR_EMPTY;
                                r_state     <= S_DONE;
                            end else begin
                                r_rsp.error <= ERR_OK;
                                r_state <= S_POP_RD_ROOT;
                            end
                        end
                    end
                end
                S_PUSH_RD: r_state <= S_PUSH_WT;
                S_PUSH_WT: r_state <= S_PUSH_CMP;
                S_PUSH_CMP: begin
                    if (r_up != '0 && rd_key > r_key) begin
                        r_cur   <= r_up;
                        r_up    <= (r_up + 2'd2) >> 2;
                        r_state <= S_PUSH_RD;
                    end else begin
                        r_rsp.entry_count <= r_count;
                        r_state           <= S_DONE;
                    end
                end
                S_POP_RD_ROOT: r_state <= S_POP_WT_ROOT;
                S_POP_WT_ROOT: begin
                    r_rsp.popped_key   <= rd_key;
                    r_rsp.popped_index <= rd_idx;
                    r_state            <= S_POP_RD_LAST;
                end
                S_POP_RD_LAST: r_state <= S_POP_WT_LAST;
                S_POP_WT_LAST: begin
                    r_key             <= rd_key;
                    r_idx             <= rd_idx;
                    r_count           <= r_count - 1'b1;
                    r_rsp.entry_count <= r_count - 1'b1;
                    r_cur             <= t_addr'(1);
                    r_first           <= t_addr'(2);
                    r_child           <= t_addr'(2);
                    if (r_count == t_count'(1)) begin
                        r_state <= S_DONE;
                    end else if (r_count == t_count'(2)) begin
                        r_state <= S_DN_DEC;
                    end else begin
                        r_state <= S_DN_RD;
                    end
                end
                S_DN_RD: r_state <= S_DN_WT;
                S_DN_WT: r_state <= S_DN_CMP;
                S_DN_CMP: begin
                    // keep the first smallest child
                    if (r_child == r_first || rd_key < r_best_key) begin
                        r_best     <= r_child;
                        r_best_key <= rd_key;
                        r_best_idx <= rd_idx;
                    end
                    if (r_child - r_first < t_addr'(3) && r_child < t_addr'(r_count)) begin
                        r_child <= r_child + 1'b1;
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_DN_DEC;
                    end
                end
                S_DN_DEC: begin
                    if (r_first <= t_addr'(r_count) && !(r_key < r_best_key)) begin
                        r_cur   <= r_best;
                        r_child <= t_addr'({r_best, 2'b00} - 3'd2);
                        if ({r_best, 2'b00} - 3'd2 <= {2'b00, r_count}) begin
                            r_first <= t_addr'({r_best, 2'b00} - 3'd2);
                            r_state <= S_DN_RD;
                        end else begin
                            r_first <= t_addr'(r_count) + 1'b1;
                            r_state <= S_DN_DEC;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> design/qmhq_ram.sv
// generic single-port ram with registered read
module qmhq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write one word when enabled; the addressed word is always read, returning the old contents on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
